### src/slcl_pkg.sv
// ----------------------------------------------------------------------------
// slcl_pkg
// Types, constants and tables shared by the stereo linked compressor blocks.
// ----------------------------------------------------------------------------
package slcl_pkg;

	localparam int REG_BANDS = 2;

	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic [1:0]         band_index;
	} smp_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} res_t;

	typedef struct packed {
		logic [REG_BANDS-1:0][48:0] curve;
		logic [REG_BANDS-1:0][31:0] times;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

	typedef enum logic [1:0] {
		REG_BAND0_CURVE = 2'd0,
		REG_BAND0_TIMES = 2'd1,
		REG_BAND1_CURVE = 2'd2,
		REG_BAND1_TIMES = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ,
		S_LMUL,
		S_GR,
		S_GRMUL,
		S_EMUL,
		S_FRAC,
		S_TGT,
		S_SMA,
		S_SMB,
		S_OL,
		S_OR,
		S_DONE
	} state_t;

	localparam logic [31:0] LOG_SCALE  = 32'd394566;
	localparam logic [31:0] EXP_SCALE  = 32'd10885;
	localparam logic [19:0] GAIN_MAX   = 20'hFFFFF;
	localparam logic [19:0] UNITY      = 20'h10000;
	localparam logic signed [15:0] LEV_SILENT = -16'sd30720;
	// offset that undoes the +65536 bias on the dB value and adds the
	// 2^31 bias plus the rounding half for the >>8
	localparam logic [32:0] EXP_BIAS =
		33'((64'd1 << 31) - 64'd65536 * 64'd10885 + 64'd128);

	typedef logic [15:0][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			b = 64'd1 << (62 - 2 * i);
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// 2^(2^-(k+1)) in Q2.30, k = 0..15
	function automatic root_tab_t build_roots();
		root_tab_t   tab;
		logic [63:0] t;
		t = isqrt64(64'd1 << 61);
		tab[0] = t[31:0];
		for (int k = 1; k < 16; k++) begin
			t = isqrt64(t << 30);
			tab[k] = t[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = build_roots();

endpackage

### src/slcl_mul.sv
// ----------------------------------------------------------------------------
// slcl_mul
// Bit-serial 32x32 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module slcl_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  slcl_pkg::mul_req_t req,
	output slcl_pkg::mul_rsp_t rsp
);

	logic [31:0] a_q;
	logic [63:0] prod_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] sum;

	assign sum = {1'b0, prod_q[63:32]} + (prod_q[0] ? {1'b0, a_q} : 33'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a;
			prod_q <= {32'd0, req.b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[31:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

### src/slcl_apb.sv
// ----------------------------------------------------------------------------
// slcl_apb
// APB register file holding the per-band curve and time constants.
// ----------------------------------------------------------------------------
module slcl_apb (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output slcl_pkg::cfg_t    cfg
);

	slcl_pkg::cfg_t     cfg_q;
	slcl_pkg::reg_idx_t idx;
	logic               wr;

	assign idx    = slcl_pkg::reg_idx_t'(paddr[4:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				slcl_pkg::REG_BAND0_CURVE: cfg_q.curve[0] <= pwdata[48:0];
				slcl_pkg::REG_BAND0_TIMES: cfg_q.times[0] <= pwdata[31:0];
				slcl_pkg::REG_BAND1_CURVE: cfg_q.curve[1] <= pwdata[48:0];
				slcl_pkg::REG_BAND1_TIMES: cfg_q.times[1] <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			slcl_pkg::REG_BAND0_CURVE: prdata = {15'd0, cfg_q.curve[0]};
			slcl_pkg::REG_BAND0_TIMES: prdata = {32'd0, cfg_q.times[0]};
			slcl_pkg::REG_BAND1_CURVE: prdata = {15'd0, cfg_q.curve[1]};
			slcl_pkg::REG_BAND1_TIMES: prdata = {32'd0, cfg_q.times[1]};
			default:                   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### src/stereo_linked_compressor_limiter.sv
// ----------------------------------------------------------------------------
// stereo_linked_compressor_limiter
// Feed-forward hard-knee compressor with linked stereo gain per band.
// ----------------------------------------------------------------------------
//  channel | signals                              | transfer when
//  sample  | smp_valid, smp_ready, smp            | smp_valid && smp_ready
//  result  | res_valid, res_ready, res            | res_valid && res_ready
//  config  | psel penable pwrite paddr pwdata ... | psel && penable && pwrite
//
//  An active band runs up to 39 products through the single bit-serial
//  multiplier, one after another; their count is set by the peak (16 log
//  squarings, none for a silent pair), the knee product and the count of set
//  exponent bits.
//  Reset clears the control and configuration registers and sets both band gains to 1.0.
//  A new sample is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module stereo_linked_compressor_limiter #(
	parameter int BANDS = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           smp_valid,
	output logic           smp_ready,
	input  slcl_pkg::smp_t smp,
	output logic           res_valid,
	input  logic           res_ready,
	output slcl_pkg::res_t res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [63:0]    pwdata,
	output logic [63:0]    prdata,
	output logic           pready
);

	slcl_pkg::cfg_t     cfg;
	slcl_pkg::mul_req_t mreq;
	slcl_pkg::mul_rsp_t mrsp;
	slcl_pkg::state_t   state_q, state_d;

	logic signed [15:0] l_q, r_q, lev_q;
	logic               band_q;
	logic [31:0]        m_q;
	logic [15:0]        frac_q, fb_q, gr_q;
	logic [3:0]         e_q, cnt_q;
	logic [7:0]         qi_q;
	logic [30:0]        p_q;
	logic [19:0]        tgt_q, ng_q, c_q;
	logic [36:0]        acc_q;
	logic [19:0]        gain_q [slcl_pkg::REG_BANDS];
	logic               issued_q;
	slcl_pkg::res_t     res_q, pend_q;
	logic               res_valid_q;

	logic        active, load, lev_gt;
	logic [15:0] al, ar, peak;
	logic [3:0]  e_in;
	logic [48:0] curve;
	logic [31:0] times;
	logic [20:0] l2mag;
	logic [16:0] diff, gb;
	logic [17:0] gdb;
	logic [32:0] qsum;
	logic [31:0] sq;
	logic [8:0]  sh;
	logic [63:0] shifted;
	logic [19:0] tgt;
	logic [38:0] ngsum;
	logic [19:0] ng;
	logic [15:0] babs;
	logic [20:0] rnd;
	logic [15:0] applied;
	logic        bneg;

	slcl_apb u_apb (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	slcl_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	assign curve = cfg.curve[band_q];
	assign times = cfg.times[band_q];

	always_comb begin
		al   = smp.left_in[15] ? 16'(-smp.left_in) : smp.left_in;
		ar   = smp.right_in[15] ? 16'(-smp.right_in) : smp.right_in;
		peak = (al > ar) ? al : ar;
		e_in = '0;
		for (int i = 0; i < 16; i++) begin
			if (peak[i]) begin
				e_in = 4'(i);
			end
		end
		active = ({1'b0, smp.band_index} < 3'(BANDS)) && !smp.band_index[1]
			&& cfg.curve[smp.band_index[0]][48];
	end

	assign load   = (state_q == slcl_pkg::S_DONE) && (!res_valid_q || res_ready);
	assign lev_gt = lev_q > $signed(curve[47:32]);
	assign sq     = mrsp.prod[61:30];
	assign l2mag  = {1'b0, 4'd15 - e_q, 16'd0} - {5'd0, frac_q};
	assign diff   = 17'({lev_q[15], lev_q} - {curve[47], curve[47:32]});
	assign gdb    = {{2{curve[15]}}, curve[15:0]} - {2'd0, gr_q};
	assign gb     = 17'(gdb + 18'h10000);
	assign qsum   = {1'b0, mrsp.prod[31:0]} + slcl_pkg::EXP_BIAS;
	assign sh     = 9'd142 - {1'b0, qi_q};
	assign shifted = ({33'd0, p_q} + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];

	always_comb begin
		if (qi_q >= 8'd132) begin
			tgt = slcl_pkg::GAIN_MAX;
		end else if (sh >= 9'd33) begin
			tgt = '0;
		end else if (shifted > 64'(slcl_pkg::GAIN_MAX)) begin
			tgt = slcl_pkg::GAIN_MAX;
		end else begin
			tgt = shifted[19:0];
		end
	end

	assign ngsum = {2'd0, acc_q} + {1'b0, mrsp.prod[37:0]} + 39'h8000;
	assign ng    = (ngsum[38:16] > 23'(slcl_pkg::GAIN_MAX)) ? slcl_pkg::GAIN_MAX
		: ngsum[35:16];

	assign bneg = (state_q == slcl_pkg::S_OL) ? l_q[15] : r_q[15];
	assign rnd  = 21'((mrsp.prod[36:0] + 37'h8000) >> 16);
	always_comb begin
		if (bneg) begin
			applied = (rnd > 21'd32768) ? 16'h8000 : 16'(17'h10000 - 17'(rnd));
		end else begin
			applied = (rnd > 21'd32767) ? 16'h7FFF : rnd[15:0];
		end
		babs = (state_q == slcl_pkg::S_OL)
			? (l_q[15] ? 16'(-l_q) : l_q) : (r_q[15] ? 16'(-r_q) : r_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slcl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mreq.start = 1'b0;
		mreq.a     = '0;
		mreq.b     = '0;
		smp_ready  = 1'b0;
		unique case (state_q)
			slcl_pkg::S_IDLE: begin
				smp_ready = 1'b1;
				if (smp_valid) begin
					state_d = !active ? slcl_pkg::S_DONE
						: (peak == '0) ? slcl_pkg::S_GR : slcl_pkg::S_SQ;
				end
			end
			slcl_pkg::S_SQ: begin
				mreq.start = !issued_q;
				mreq.a     = m_q;
				mreq.b     = m_q;
				if (mrsp.done && cnt_q == 4'd15) begin
					state_d = slcl_pkg::S_LMUL;
				end
			end
			slcl_pkg::S_LMUL: begin
				mreq.start = !issued_q;
				mreq.a     = slcl_pkg::LOG_SCALE;
				mreq.b     = {12'd0, l2mag[19:0]};
				if (mrsp.done) begin
					state_d = slcl_pkg::S_GR;
				end
			end
			slcl_pkg::S_GR: begin
				state_d = lev_gt ? slcl_pkg::S_GRMUL : slcl_pkg::S_EMUL;
			end
			slcl_pkg::S_GRMUL: begin
				mreq.start = !issued_q;
				mreq.a     = {16'd0, curve[31:16]};
				mreq.b     = {15'd0, diff};
				if (mrsp.done) begin
					state_d = slcl_pkg::S_EMUL;
				end
			end
			slcl_pkg::S_EMUL: begin
				mreq.start = !issued_q;
				mreq.a     = slcl_pkg::EXP_SCALE;
				mreq.b     = {15'd0, gb};
				if (mrsp.done) begin
					state_d = slcl_pkg::S_FRAC;
				end
			end
			slcl_pkg::S_FRAC: begin
				mreq.a = {1'b0, p_q};
				mreq.b = slcl_pkg::ROOT_TAB[cnt_q];
				if (!fb_q[15]) begin
					if (cnt_q == 4'd15) begin
						state_d = slcl_pkg::S_TGT;
					end
				end else begin
					mreq.start = !issued_q;
					if (mrsp.done && cnt_q == 4'd15) begin
						state_d = slcl_pkg::S_TGT;
					end
				end
			end
			slcl_pkg::S_TGT: state_d = slcl_pkg::S_SMA;
			slcl_pkg::S_SMA: begin
				mreq.start = !issued_q;
				mreq.a     = {12'd0, gain_q[band_q]};
				mreq.b     = {12'd0, c_q};
				if (mrsp.done) begin
					state_d = slcl_pkg::S_SMB;
				end
			end
			slcl_pkg::S_SMB: begin
				mreq.start = !issued_q;
				mreq.a     = {12'd0, tgt_q};
				mreq.b     = {12'd0, 20'h10000 - c_q};
				if (mrsp.done) begin
					state_d = slcl_pkg::S_OL;
				end
			end
			slcl_pkg::S_OL, slcl_pkg::S_OR: begin
				mreq.start = !issued_q;
				mreq.a     = {12'd0, ng_q};
				mreq.b     = {16'd0, babs};
				if (mrsp.done) begin
					state_d = (state_q == slcl_pkg::S_OL) ? slcl_pkg::S_OR
						: slcl_pkg::S_DONE;
				end
			end
			slcl_pkg::S_DONE: begin
				if (load) begin
					state_d = slcl_pkg::S_IDLE;
				end
			end
			default: state_d = slcl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int b = 0; b < slcl_pkg::REG_BANDS; b++) begin
				gain_q[b] <= slcl_pkg::UNITY;
			end
		end else begin
			if (mreq.start) begin
				issued_q <= 1'b1;
			end else if (mrsp.done) begin
				issued_q <= 1'b0;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == slcl_pkg::S_SMB && mrsp.done) begin
				gain_q[band_q] <= ng;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= pend_q;
		end
		unique case (state_q)
			slcl_pkg::S_IDLE: begin
				l_q    <= smp.left_in;
				r_q    <= smp.right_in;
				band_q <= smp.band_index[0];
				pend_q <= {smp.left_in, smp.right_in};
				lev_q  <= slcl_pkg::LEV_SILENT;
				m_q    <= {16'd0, peak} << (5'd30 - {1'b0, e_in});
				e_q    <= e_in;
				frac_q <= '0;
				cnt_q  <= '0;
				gr_q   <= '0;
			end
			slcl_pkg::S_SQ: begin
				if (mrsp.done) begin
					m_q    <= sq[31] ? {1'b0, sq[31:1]} : sq;
					frac_q <= {frac_q[14:0], sq[31]};
					cnt_q  <= cnt_q + 4'd1;
				end
			end
			slcl_pkg::S_LMUL: begin
				if (mrsp.done) begin
					lev_q <= 16'(-((mrsp.prod[39:0] + 40'h800000) >> 24));
				end
			end
			slcl_pkg::S_GRMUL: begin
				if (mrsp.done) begin
					gr_q <= 16'((mrsp.prod[32:0] + 33'h8000) >> 16);
				end
			end
			slcl_pkg::S_EMUL: begin
				if (mrsp.done) begin
					qi_q  <= qsum[31:24];
					fb_q  <= qsum[23:8];
					p_q   <= 31'h40000000;
					cnt_q <= '0;
				end
			end
			slcl_pkg::S_FRAC: begin
				if (!fb_q[15] || mrsp.done) begin
					fb_q  <= {fb_q[14:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
				end
				if (fb_q[15] && mrsp.done) begin
					p_q <= mrsp.prod[60:30];
				end
			end
			slcl_pkg::S_TGT: begin
				tgt_q <= tgt;
				c_q   <= (tgt < gain_q[band_q]) ? {4'd0, times[31:16]}
					: {4'd0, times[15:0]};
			end
			slcl_pkg::S_SMA: begin
				if (mrsp.done) begin
					acc_q <= mrsp.prod[36:0];
				end
			end
			slcl_pkg::S_SMB: begin
				if (mrsp.done) begin
					ng_q <= ng;
				end
			end
			slcl_pkg::S_OL: begin
				if (mrsp.done) begin
					pend_q.left_out <= applied;
				end
			end
			slcl_pkg::S_OR: begin
				if (mrsp.done) begin
					pend_q.right_out <= applied;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> state_q != slcl_pkg::S_IDLE)
		else $error("sample transfer did not start work");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == slcl_pkg::S_DONE))
		else $error("result loaded outside done state");

	a_gain0_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(gain_q[0]) |-> $past(state_q == slcl_pkg::S_SMB))
		else $error("band 0 gain changed outside smoothing");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> issued_q)
		else $error("multiplier finished with no product pending");

endmodule
